// ===== design/psp_pkg.sv =====
// shared types and constants for the pixel swizzle and premultiply pipeline
// no dependencies; imported by every module of the block
package psp_pkg;

  // source layout codes held in the format register
  typedef enum logic [2:0] {
    FMT_ALPHA     = 3'd0,
    FMT_LUM_ALPHA = 3'd1,
    FMT_RGBA      = 3'd2,
    FMT_BGRA      = 3'd3,
    FMT_ARGB      = 3'd4,
    FMT_RGB       = 3'd5,
    FMT_BGR       = 3'd6
  } fmt_e;

  localparam logic [2:0] FMT_RESET     = FMT_RGBA;
  localparam logic [7:0] CHAN_MAX      = 8'd255;
  localparam logic [7:0] ROUND_BIAS    = 8'd127;
  localparam int         PROD_W        = 16;

  // input beat
  typedef struct packed {
    logic [7:0] byte_lane0;
    logic [7:0] byte_lane1;
    logic [7:0] byte_lane2;
    logic [7:0] byte_lane3;
    logic       in_last;
  } pix_in_t;

  // result beat
  typedef struct packed {
    logic [7:0] red_premul;
    logic [7:0] green_premul;
    logic [7:0] blue_premul;
    logic [7:0] alpha_out;
    logic       out_last;
  } pix_out_t;

  // swizzled pixel between stage 1 and stage 2
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } rgba_t;

  // rounded products between stage 2 and stage 3
  typedef struct packed {
    logic [PROD_W-1:0] pr;
    logic [PROD_W-1:0] pg;
    logic [PROD_W-1:0] pb;
    logic [7:0]        a;
    logic              last;
  } prod_t;

endpackage

// ===== design/psp_swizzle.sv =====
// stage 1: maps raw byte lanes to r, g, b, a by source layout
// depends on psp_pkg
module psp_swizzle (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      fmt,
  input  logic            up_valid,
  output logic            up_ready,
  input  psp_pkg::pix_in_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output psp_pkg::rgba_t  dn_data
);
  import psp_pkg::*;

  logic  valid_r;
  rgba_t data_r;
  rgba_t data_nxt;

  // lane select per layout; undefined code gives zero color and alpha
  always_comb begin
    data_nxt      = '0;
    data_nxt.last = up_data.in_last;
    unique case (fmt)
      FMT_ALPHA: begin
        data_nxt.r = CHAN_MAX;
        data_nxt.g = CHAN_MAX;
        data_nxt.b = CHAN_MAX;
        data_nxt.a = up_data.byte_lane0;
      end
      FMT_LUM_ALPHA: begin
        data_nxt.r = up_data.byte_lane0;
        data_nxt.g = up_data.byte_lane0;
        data_nxt.b = up_data.byte_lane0;
        data_nxt.a = up_data.byte_lane1;
      end
      FMT_RGBA: begin
        data_nxt.r = up_data.byte_lane0;
        data_nxt.g = up_data.byte_lane1;
        data_nxt.b = up_data.byte_lane2;
        data_nxt.a = up_data.byte_lane3;
      end
      FMT_BGRA: begin
        data_nxt.r = up_data.byte_lane2;
        data_nxt.g = up_data.byte_lane1;
        data_nxt.b = up_data.byte_lane0;
        data_nxt.a = up_data.byte_lane3;
      end
      FMT_ARGB: begin
        data_nxt.r = up_data.byte_lane1;
        data_nxt.g = up_data.byte_lane2;
        data_nxt.b = up_data.byte_lane3;
        data_nxt.a = up_data.byte_lane0;
      end
      FMT_RGB: begin
        data_nxt.r = up_data.byte_lane0;
        data_nxt.g = up_data.byte_lane1;
        data_nxt.b = up_data.byte_lane2;
        data_nxt.a = CHAN_MAX;
      end
      FMT_BGR: begin
        data_nxt.r = up_data.byte_lane2;
        data_nxt.g = up_data.byte_lane1;
        data_nxt.b = up_data.byte_lane0;
        data_nxt.a = CHAN_MAX;
      end
      default: begin
        data_nxt.r = '0;
      end
    endcase
  end

  // stage takes a beat when empty or when its beat moves on
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/psp_mult.sv =====
// stage 2: multiplies each color channel by alpha and adds the rounding bias
// depends on psp_pkg
module psp_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  psp_pkg::rgba_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output psp_pkg::prod_t dn_data
);
  import psp_pkg::*;

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  // c*a + 127 stays below 2^16
  always_comb begin
    data_nxt.pr   = {8'd0, up_data.r} * {8'd0, up_data.a} + {8'd0, ROUND_BIAS};
    data_nxt.pg   = {8'd0, up_data.g} * {8'd0, up_data.a} + {8'd0, ROUND_BIAS};
    data_nxt.pb   = {8'd0, up_data.b} * {8'd0, up_data.a} + {8'd0, ROUND_BIAS};
    data_nxt.a    = up_data.a;
    data_nxt.last = up_data.last;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/psp_div.sv =====
// stage 3: divides the rounded products by 255 and forms the result beat
// depends on psp_pkg
module psp_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  psp_pkg::prod_t   up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output psp_pkg::pix_out_t dn_data
);
  import psp_pkg::*;

  logic     valid_r;
  pix_out_t data_r;
  pix_out_t data_nxt;

  // x/255 as (x + 1 + (x >> 8)) >> 8, exact for x below 65280
  function automatic logic [7:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + {{PROD_W{1'b0}}, 1'b1} + {9'd0, x[PROD_W-1:8]};
    return s[15:8];
  endfunction

  always_comb begin
    data_nxt.red_premul   = div255(up_data.pr);
    data_nxt.green_premul = div255(up_data.pg);
    data_nxt.blue_premul  = div255(up_data.pb);
    data_nxt.alpha_out    = up_data.a;
    data_nxt.out_last     = up_data.last;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== design/pixel_swizzle_premultiply_unit.sv =====
// throughput: one beat per cycle while out_ready is high; each accepted input beat
// passes through registered swizzle, multiply and divide-by-255 stages, which
// stall together from out_ready back to in_ready, losing no beat
// reset (rst_n low, synchronous): pipeline emptied, format register set to rgba
// top level of the pixel swizzle and premultiply pipeline
// depends on psp_pkg, psp_swizzle, psp_mult, psp_div
module pixel_swizzle_premultiply_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  psp_pkg::pix_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output psp_pkg::pix_out_t  out_data
);
  import psp_pkg::*;

  logic [2:0] fmt_r;
  logic       s1_valid;
  logic       s1_ready;
  rgba_t      s1_data;
  logic       s2_valid;
  logic       s2_ready;
  prod_t      s2_data;

  // format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  psp_swizzle u_swizzle (
    .clk      (clk),
    .rst_n    (rst_n),
    .fmt      (fmt_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  psp_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  psp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  // a ready sink never stalls the pipe
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("pipeline stalls with sink ready");

  // premultiplied colors never exceed alpha
  a_premul_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_premul <= out_data.alpha_out) &&
                  (out_data.green_premul <= out_data.alpha_out) &&
                  (out_data.blue_premul <= out_data.alpha_out))
    else $error("premultiplied channel above alpha");

  // a register write shows on the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> fmt_r == $past(cfg_wr_data))
    else $error("format register write lost");

endmodule

// ===== tb/sv/tb_pixel_swizzle_premultiply_unit.sv =====
// testbench for pixel_swizzle_premultiply_unit: swizzle and alpha premultiply checks
// per source format, with random source bytes, sender bursts and receiver stalls
// depends on psp_pkg and the pixel_swizzle_premultiply_unit rtl
module tb_pixel_swizzle_premultiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;

  // code 7 is not a defined layout, the block must output zero color and alpha
  localparam logic [2:0] FMT_UNDEF    = 3'd7;
  localparam int         PIPE_LATENCY = 3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         CYCLE_LIMIT  = 200000;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_BURSTY, SINK_SPARSE} sink_mode_e;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     cfg_wr_en   = 1'b0;
  logic [2:0] cfg_wr_data = FMT_RESET;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  pix_in_t  in_data     = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  pix_out_t out_data;

  pix_out_t   premul_expected[$];
  logic [2:0] cur_format    = FMT_RESET;
  sink_mode_e sink_mode     = SINK_ALWAYS;
  bit         hold_req      = 1'b0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  pixel_swizzle_premultiply_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // rounded premultiply of one channel
  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    int prod;
    prod = int'(c) * int'(a) + int'(ROUND_BIAS);
    return 8'(prod / int'(CHAN_MAX));
  endfunction

  // expected result beat for one source pixel under a given layout
  function automatic pix_out_t premul_pixel(input pix_in_t p, input logic [2:0] fmt);
    logic [7:0] r, g, b, a;
    pix_out_t o;
    r = '0; g = '0; b = '0; a = '0;
    case (fmt)
      FMT_ALPHA: begin
        r = CHAN_MAX; g = CHAN_MAX; b = CHAN_MAX; a = p.byte_lane0;
      end
      FMT_LUM_ALPHA: begin
        r = p.byte_lane0; g = p.byte_lane0; b = p.byte_lane0; a = p.byte_lane1;
      end
      FMT_RGBA: begin
        r = p.byte_lane0; g = p.byte_lane1; b = p.byte_lane2; a = p.byte_lane3;
      end
      FMT_BGRA: begin
        r = p.byte_lane2; g = p.byte_lane1; b = p.byte_lane0; a = p.byte_lane3;
      end
      FMT_ARGB: begin
        r = p.byte_lane1; g = p.byte_lane2; b = p.byte_lane3; a = p.byte_lane0;
      end
      FMT_RGB: begin
        r = p.byte_lane0; g = p.byte_lane1; b = p.byte_lane2; a = CHAN_MAX;
      end
      FMT_BGR: begin
        r = p.byte_lane2; g = p.byte_lane1; b = p.byte_lane0; a = CHAN_MAX;
      end
      default: ;
    endcase
    o.red_premul   = scale_by_alpha(r, a);
    o.green_premul = scale_by_alpha(g, a);
    o.blue_premul  = scale_by_alpha(b, a);
    o.alpha_out    = a;
    o.out_last     = p.in_last;
    return o;
  endfunction

  // random pixel, lanes biased toward the byte extremes
  function automatic pix_in_t rand_pixel();
    pix_in_t    p;
    logic [7:0] lane [4];
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 5))
        0:       lane[j] = 8'h00;
        1:       lane[j] = 8'hFF;
        2:       lane[j] = 8'h01;
        3:       lane[j] = 8'hFE;
        default: lane[j] = 8'($urandom);
      endcase
    end
    p.byte_lane0 = lane[0];
    p.byte_lane1 = lane[1];
    p.byte_lane2 = lane[2];
    p.byte_lane3 = lane[3];
    p.in_last    = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h",
             field, cycle_count, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (premul_expected.size() == 0) begin
        report_mismatch("unexpected beat", out_data.alpha_out, 8'h00);
      end else begin
        want = premul_expected.pop_front();
        if (out_data.red_premul !== want.red_premul)
          report_mismatch("red_premul", out_data.red_premul, want.red_premul);
        if (out_data.green_premul !== want.green_premul)
          report_mismatch("green_premul", out_data.green_premul, want.green_premul);
        if (out_data.blue_premul !== want.blue_premul)
          report_mismatch("blue_premul", out_data.blue_premul, want.blue_premul);
        if (out_data.alpha_out !== want.alpha_out)
          report_mismatch("alpha_out", out_data.alpha_out, want.alpha_out);
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", 8'(out_data.out_last), 8'(want.out_last));
      end
    end
  end

  // receiver: stall pattern per mode, plus a long hold-off on request
  initial begin : sink
    int run_left;
    bit run_ready;
    run_left  = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: out_ready <= 1'b1;
          SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (run_left == 0) begin
              run_ready = ~run_ready;
              run_left  = $urandom_range(1, 12);
            end
            run_left--;
            out_ready <= run_ready;
          end
        endcase
      end
    end
  end

  // one input beat; valid stays up for a following beat
  task automatic send_pixel(input pix_in_t pix);
    in_valid <= 1'b1;
    in_data  <= pix;
    do @(posedge clk); while (!in_ready);
    premul_expected.insert(premul_expected.size(), premul_pixel(pix, cur_format));
  endtask

  // random pixels in bursts with random idle gaps
  task automatic send_stream(input int count, input int max_burst, input int max_gap);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, max_burst);
      for (int k = 0; k < burst && count > 0; k++) begin
        send_pixel(rand_pixel());
        count--;
      end
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain the pipeline before touching the register
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (premul_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic set_format(input logic [2:0] fmt);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= fmt;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_format  = fmt;
  endtask

  // corner pixels: opaque/transparent alpha, full and empty channels
  task automatic send_corners();
    send_pixel('{8'hFF, 8'h00, 8'h80, 8'hFF, 1'b1});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0});
    send_pixel('{8'h01, 8'hFE, 8'h7F, 8'h80, 1'b1});
  endtask

  // rgba layout straight out of reset, no register write
  task automatic test_reset_format();
    sink_mode = SINK_ALWAYS;
    send_corners();
  endtask

  // every other layout, the undefined code included
  task automatic test_each_format();
    logic [2:0] fmts [7];
    fmts = '{FMT_ALPHA, FMT_LUM_ALPHA, FMT_BGRA, FMT_ARGB, FMT_RGB, FMT_BGR, FMT_UNDEF};
    foreach (fmts[i]) begin
      set_format(fmts[i]);
      send_corners();
    end
  endtask

  // random pixels per layout with varied sender and receiver idling
  task automatic test_random_formats();
    logic [2:0] fmts [8];
    sink_mode_e modes [4];
    fmts  = '{FMT_RGB, FMT_ALPHA, FMT_UNDEF, FMT_BGRA, FMT_LUM_ALPHA, FMT_BGR,
              FMT_ARGB, FMT_RGBA};
    modes = '{SINK_ALWAYS, SINK_RANDOM, SINK_BURSTY, SINK_SPARSE};
    foreach (fmts[i]) begin
      set_format(fmts[i]);
      sink_mode = modes[i % 4];
      send_stream(110, 1 + $urandom_range(0, 15), (i % 3 == 0) ? 0 : 2 + 3 * (i % 3));
    end
  endtask

  // receiver holds off long while beats keep coming, input must back up
  task automatic test_output_hold_off();
    set_format(FMT_ARGB);
    sink_mode = SINK_ALWAYS;
    hold_req  = 1'b1;
    send_stream(40, 40, 0);
    sink_mode = SINK_BURSTY;
    send_stream(20, 8, 3);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_format();
    test_each_format();
    test_random_formats();
    test_output_hold_off();
    wait_idle();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && premul_expected.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
